[hw/rtl/fzm_pkg.sv]
// ----------------------------------------------------------------------------
// fzm_pkg
// Shared constants and types of the Z-shaped fuzzy membership unit.
// ----------------------------------------------------------------------------
package fzm_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned DEG_W         = 17;
  localparam int unsigned REG_IDX_W     = 1;

  localparam logic [REG_IDX_W-1:0] REG_BOUND_F = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_BOUND_U = 1'b1;

  // Where the sample sits on the falling curve
  typedef enum logic [1:0] {
    Z_FULL,   // z = ONE
    Z_EMPTY,  // z = 0
    Z_HEAD,   // z = ONE - T(x - lo)
    Z_TAIL    // z = T(hi - x)
  } kind_e;

  typedef struct packed {
    kind_e kind;
    logic  swap;  // bounds swapped: u takes the falling curve
  } ctl_t;

endpackage

[hw/rtl/fzm_prep.sv]
// ----------------------------------------------------------------------------
// fzm_prep
// Front stage: orders the bounds, classifies the sample and forms the
// dividend offset and span for the divider chain.
// ----------------------------------------------------------------------------
module fzm_prep (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [fzm_pkg::DATA_W-1:0]  sample_i,
  input  logic [fzm_pkg::DATA_W-1:0]  bound_f_i,
  input  logic [fzm_pkg::DATA_W-1:0]  bound_u_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [fzm_pkg::DATA_W-1:0]  rem_o,
  output logic [fzm_pkg::DATA_W-1:0]  div_o,
  output fzm_pkg::ctl_t               ctl_o
);
  import fzm_pkg::*;

  logic signed [DATA_W-1:0] x, bf, bu, lo, hi;
  logic signed [DATA_W+1:0] mid_sum, x_dbl;
  logic signed [DATA_W:0]   span, off_head, off_tail;
  logic                     lt, gt;
  logic [DATA_W-1:0]        rem_d, div_d;
  ctl_t                     ctl_d;

  logic                     valid_q;
  logic [DATA_W-1:0]        rem_q, div_q;
  ctl_t                     ctl_q;

  always_comb begin
    x        = signed'(sample_i);
    bf       = signed'(bound_f_i);
    bu       = signed'(bound_u_i);
    lt       = bf < bu;
    gt       = bu < bf;
    lo       = gt ? bu : bf;
    hi       = gt ? bf : bu;
    mid_sum  = (DATA_W+2)'(lo) + (DATA_W+2)'(hi);
    x_dbl    = (DATA_W+2)'(x) <<< 1;
    span     = (DATA_W+1)'(hi) - (DATA_W+1)'(lo);
    off_head = (DATA_W+1)'(x) - (DATA_W+1)'(lo);
    off_tail = (DATA_W+1)'(hi) - (DATA_W+1)'(x);
    div_d    = span[DATA_W-1:0];
    rem_d    = '0;
    ctl_d.swap = gt;
    if (!lt && !gt) begin
      ctl_d.kind = (x < lo) ? Z_FULL : Z_EMPTY;
    end else if (x <= lo) begin
      ctl_d.kind = Z_FULL;
    end else if (x_dbl <= mid_sum) begin
      ctl_d.kind = Z_HEAD;
      rem_d      = off_head[DATA_W-1:0];
    end else if (x <= hi) begin
      ctl_d.kind = Z_TAIL;
      rem_d      = off_tail[DATA_W-1:0];
    end else begin
      ctl_d.kind = Z_EMPTY;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      rem_q <= rem_d;
      div_q <= div_d;
      ctl_q <= ctl_d;
    end
  end

  assign out_valid_o = valid_q;
  assign rem_o       = rem_q;
  assign div_o       = div_q;
  assign ctl_o       = ctl_q;

endmodule

[hw/rtl/fzm_div_cell.sv]
// ----------------------------------------------------------------------------
// fzm_div_cell
// One restoring division cell: yields one quotient bit and passes the
// partial remainder, span and control on to the next cell.
// ----------------------------------------------------------------------------
module fzm_div_cell #(
  parameter int unsigned FRAC_BITS = fzm_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [fzm_pkg::DATA_W-1:0]  rem_i,
  input  logic [FRAC_BITS-1:0]        quo_i,
  input  logic [fzm_pkg::DATA_W-1:0]  div_i,
  input  fzm_pkg::ctl_t               ctl_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [fzm_pkg::DATA_W-1:0]  rem_o,
  output logic [FRAC_BITS-1:0]        quo_o,
  output logic [fzm_pkg::DATA_W-1:0]  div_o,
  output fzm_pkg::ctl_t               ctl_o
);
  import fzm_pkg::*;

  logic [DATA_W:0]   dbl;
  logic [DATA_W+1:0] diff;
  logic              take;

  logic              valid_q;
  logic [DATA_W-1:0] rem_q, div_q;
  logic [FRAC_BITS-1:0] quo_q;
  ctl_t              ctl_q;

  always_comb begin
    dbl  = {rem_i, 1'b0};
    diff = {1'b0, dbl} - {2'b00, div_i};
    take = !diff[DATA_W+1];
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      rem_q <= take ? diff[DATA_W-1:0] : dbl[DATA_W-1:0];
      quo_q <= {quo_i[FRAC_BITS-2:0], take};
      div_q <= div_i;
      ctl_q <= ctl_i;
    end
  end

  assign out_valid_o = valid_q;
  assign rem_o       = rem_q;
  assign quo_o       = quo_q;
  assign div_o       = div_q;
  assign ctl_o       = ctl_q;

endmodule

[hw/rtl/fzm_post.sv]
// ----------------------------------------------------------------------------
// fzm_post
// Back end: rounds the ratio, squares it, rounds 2r^2 and forms f and u.
// Three registered stages with their own valid bits.
// ----------------------------------------------------------------------------
module fzm_post #(
  parameter int unsigned FRAC_BITS = fzm_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [fzm_pkg::DATA_W-1:0]  rem_i,
  input  logic [FRAC_BITS-1:0]        quo_i,
  input  logic [fzm_pkg::DATA_W-1:0]  div_i,
  input  fzm_pkg::ctl_t               ctl_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [fzm_pkg::DEG_W-1:0]   f_degree_o,
  output logic [fzm_pkg::DEG_W-1:0]   u_degree_o
);
  import fzm_pkg::*;

  localparam logic [FRAC_BITS:0]     One = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [2*FRAC_BITS:0]   Rnd = (2*FRAC_BITS+1)'(1) << (FRAC_BITS-2);

  logic [DATA_W:0]      half_sum;
  logic                 bump;
  logic [2*FRAC_BITS:0] sq_rnd;
  logic [FRAC_BITS:0]   tval, zval, fval, uval;
  logic [31:0]          f_wide, u_wide;

  logic                 v1_q, v2_q, v3_q;
  logic                 rdy1, rdy2, rdy3;
  logic [FRAC_BITS-1:0] r_q;
  logic [2*FRAC_BITS-1:0] sq_q;
  ctl_t                 ctl1_q, ctl2_q;
  logic [DEG_W-1:0]     f_q, u_q;

  // rounding half up: remainder plus floor(d/2) reaching d adds one
  always_comb begin
    half_sum = {1'b0, rem_i} + {2'b00, div_i[DATA_W-1:1]};
    bump     = half_sum >= {1'b0, div_i};
  end

  always_comb begin
    sq_rnd = {1'b0, sq_q} + Rnd;
    tval   = sq_rnd[2*FRAC_BITS-1:FRAC_BITS-1];
    case (ctl2_q.kind)
      Z_FULL:  zval = One;
      Z_EMPTY: zval = '0;
      Z_HEAD:  zval = One - tval;
      Z_TAIL:  zval = tval;
      default: zval = '0;
    endcase
    fval   = ctl2_q.swap ? One - zval : zval;
    uval   = One - fval;
    f_wide = 32'(fval);
    u_wide = 32'(uval);
  end

  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy1) begin
      r_q    <= quo_i + FRAC_BITS'(bump);
      ctl1_q <= ctl_i;
    end
    if (v1_q && rdy2) begin
      sq_q   <= r_q * r_q;
      ctl2_q <= ctl1_q;
    end
    if (v2_q && rdy3) begin
      f_q <= f_wide[DEG_W-1:0];
      u_q <= u_wide[DEG_W-1:0];
    end
  end

  assign out_valid_o = v3_q;
  assign f_degree_o  = f_q;
  assign u_degree_o  = u_q;

endmodule

[hw/rtl/fuzzy_z_membership_unit.sv]
// ----------------------------------------------------------------------------
// fuzzy_z_membership_unit
// Z-shaped fuzzy membership: returns degree f and complement u of a signed
// sample against two configured bounds, 2^FRAC_BITS meaning 1.0.
//
//   channel  direction  handshake                 payload
//   in       in         in_valid_i / in_ready_o   sample_i
//   out      out        out_valid_o / out_ready_i f_degree_o, u_degree_o
//   cfg      in         cfg_we_i                  cfg_addr_i, cfg_wdata_i
//
// One request accepted per cycle until a stall fills every stage; one front
// stage, one division cell per quotient bit, three back-end stages.
// Each stage has its own valid bit, so bubbles close up under a stall and
// input keeps flowing until every stage is full.
// Reset clears the valid bits and both bounds to zero.
// ----------------------------------------------------------------------------
module fuzzy_z_membership_unit #(
  parameter int unsigned FRAC_BITS = fzm_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [fzm_pkg::DATA_W-1:0]    sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [fzm_pkg::DEG_W-1:0]     f_degree_o,
  output logic [fzm_pkg::DEG_W-1:0]     u_degree_o,
  input  logic                          cfg_we_i,
  input  logic [fzm_pkg::REG_IDX_W-1:0] cfg_addr_i,
  input  logic [fzm_pkg::DATA_W-1:0]    cfg_wdata_i
);
  import fzm_pkg::*;

  logic [DATA_W-1:0]    bound_f_q, bound_u_q;

  logic                 valid_w [FRAC_BITS+1];
  logic                 ready_w [FRAC_BITS+1];
  logic [DATA_W-1:0]    rem_w   [FRAC_BITS+1];
  logic [DATA_W-1:0]    div_w   [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] quo_w   [FRAC_BITS+1];
  ctl_t                 ctl_w   [FRAC_BITS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_f_q <= '0;
      bound_u_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_BOUND_F: bound_f_q <= cfg_wdata_i;
        REG_BOUND_U: bound_u_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  fzm_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .bound_f_i   (bound_f_q),
    .bound_u_i   (bound_u_q),
    .out_valid_o (valid_w[0]),
    .out_ready_i (ready_w[0]),
    .rem_o       (rem_w[0]),
    .div_o       (div_w[0]),
    .ctl_o       (ctl_w[0])
  );

  assign quo_w[0] = '0;

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_cell
    fzm_div_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid_w[i]),
      .in_ready_o  (ready_w[i]),
      .rem_i       (rem_w[i]),
      .quo_i       (quo_w[i]),
      .div_i       (div_w[i]),
      .ctl_i       (ctl_w[i]),
      .out_valid_o (valid_w[i+1]),
      .out_ready_i (ready_w[i+1]),
      .rem_o       (rem_w[i+1]),
      .quo_o       (quo_w[i+1]),
      .div_o       (div_w[i+1]),
      .ctl_o       (ctl_w[i+1])
    );
  end

  fzm_post #(.FRAC_BITS(FRAC_BITS)) u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (valid_w[FRAC_BITS]),
    .in_ready_o  (ready_w[FRAC_BITS]),
    .rem_i       (rem_w[FRAC_BITS]),
    .quo_i       (quo_w[FRAC_BITS]),
    .div_i       (div_w[FRAC_BITS]),
    .ctl_i       (ctl_w[FRAC_BITS]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .f_degree_o  (f_degree_o),
    .u_degree_o  (u_degree_o)
  );

endmodule

[hw/rtl/fzm_checker.sv]
// ----------------------------------------------------------------------------
// fzm_checker
// Port-level checks of the fuzzy membership unit, bound to the top level.
// ----------------------------------------------------------------------------
module fzm_checker #(
  parameter int unsigned FRAC_BITS = fzm_pkg::FRAC_BITS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [fzm_pkg::DATA_W-1:0]    sample_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [fzm_pkg::DEG_W-1:0]     f_degree_o,
  input logic [fzm_pkg::DEG_W-1:0]     u_degree_o,
  input logic                          cfg_we_i,
  input logic [fzm_pkg::REG_IDX_W-1:0] cfg_addr_i,
  input logic [fzm_pkg::DATA_W-1:0]    cfg_wdata_i
);
  import fzm_pkg::*;

  localparam bit          Fits = FRAC_BITS <= DEG_W - 1;
  localparam logic [DEG_W:0] OneW = (DEG_W+1)'(1) << FRAC_BITS;

  logic [DEG_W:0] deg_sum;
  assign deg_sum = {1'b0, f_degree_o} + {1'b0, u_degree_o};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(f_degree_o)
      && $stable(u_degree_o))
    else $error("result changed while stalled");

  a_complement: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && Fits |-> deg_sum == OneW)
    else $error("f and u do not add up to one");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && Fits |-> {1'b0, f_degree_o} <= OneW)
    else $error("degree above one");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input blocked while output is free");

endmodule

bind fuzzy_z_membership_unit fzm_checker #(.FRAC_BITS(FRAC_BITS)) u_fzm_checker (.*);
